[rtl/core/cohp_pkg.sv]
// ---------------------------------------------------------------------------
// cohp_pkg
// Shared types and constants of the option header parser.
// ---------------------------------------------------------------------------
package cohp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned NUM_W  = 16;
	localparam int unsigned LEN_W  = 17;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

	// Nibble codes of a header byte.
	localparam logic [3:0] NIB_EXT1    = 4'd13;
	localparam logic [3:0] NIB_EXT2    = 4'd14;
	localparam logic [3:0] NIB_INVALID = 4'd15;

	// Offsets added to extension bytes.
	localparam logic [LEN_W-1:0] EXT1_BASE = 17'd13;
	localparam logic [LEN_W-1:0] EXT2_BASE = 17'd269;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              start_of_options;
	} cohp_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NUM_W-1:0]  option_number;
		logic [LEN_W-1:0]  value_length;
		logic [BYTE_W-1:0] value_byte;
		logic              last;
	} cohp_result_t;

endpackage

[rtl/core/cohp_if.sv]
// ---------------------------------------------------------------------------
// cohp_if
// Valid/ready channels for option bytes in and parse results out.
// ---------------------------------------------------------------------------
interface cohp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       start_of_options;

	modport source (output valid, output byte_in, output start_of_options, input ready);
	modport sink   (input valid, input byte_in, input start_of_options, output ready);
endinterface

interface cohp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] option_number;
	logic [16:0] value_length;
	logic [7:0]  value_byte;
	logic        last;

	modport source (output valid, output kind, output option_number, output value_length,
		output value_byte, output last, input ready);
	modport sink   (input valid, input kind, input option_number, input value_length,
		input value_byte, input last, output ready);
endinterface

[rtl/core/cohp_in_stage.sv]
// ---------------------------------------------------------------------------
// cohp_in_stage
// Input register that holds one accepted byte until the parser consumes it.
// ---------------------------------------------------------------------------
module cohp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cohp_pkg::cohp_item_t in_item,
	input  logic               advance,
	output logic               valid_s1,
	output cohp_pkg::cohp_item_t item_s1
);
	import cohp_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end
endmodule

[rtl/core/cohp_core.sv]
// ---------------------------------------------------------------------------
// cohp_core
// Parser state and the per-byte decode of delta, length and value bytes.
// ---------------------------------------------------------------------------
module cohp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  cohp_pkg::cohp_item_t item_s1,
	output logic                 has_result,
	output cohp_pkg::cohp_result_t result
);
	import cohp_pkg::*;

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_D1   = 3'd1;
	localparam logic [2:0] PH_D2   = 3'd2;
	localparam logic [2:0] PH_L1   = 3'd3;
	localparam logic [2:0] PH_L2   = 3'd4;
	localparam logic [2:0] PH_VAL  = 3'd5;
	localparam logic [2:0] PH_HALT = 3'd6;

	typedef struct packed {
		logic [2:0]        phase;
		logic [NUM_W-1:0]  running_number;
		logic [3:0]        delta_code;
		logic [3:0]        length_code;
		logic [BYTE_W-1:0] extension_high;
		logic [LEN_W-1:0]  pending_delta;
		logic [LEN_W-1:0]  remaining_bytes;
	} cohp_state_t;

	cohp_state_t state_q;
	cohp_state_t state_nxt;

	always_comb begin
		logic [2:0]        ph;
		logic [NUM_W-1:0]  run;
		logic [BYTE_W-1:0] b;
		logic              do_after;
		logic              do_finish;
		logic              do_fail;
		logic [LEN_W:0]    sum;

		state_nxt  = state_q;
		result     = '0;
		has_result = 1'b0;
		do_after   = 1'b0;
		do_finish  = 1'b0;
		do_fail    = 1'b0;
		b          = item_s1.byte_in;
		ph         = state_q.phase;
		run        = state_q.running_number;

		// A start flag abandons any option in progress.
		if (item_s1.start_of_options) begin
			ph  = PH_HDR;
			run = '0;
		end
		state_nxt.phase          = ph;
		state_nxt.running_number = run;

		case (ph)
			PH_HALT: begin
			end
			PH_D1: begin
				if (state_q.delta_code == NIB_EXT1) begin
					state_nxt.pending_delta = EXT1_BASE + {9'd0, b};
					do_after = 1'b1;
				end else begin
					state_nxt.extension_high = b;
					state_nxt.phase = PH_D2;
				end
			end
			PH_D2: begin
				state_nxt.pending_delta = EXT2_BASE + {1'b0, state_q.extension_high, b};
				do_after = 1'b1;
			end
			PH_L1: begin
				if (state_q.length_code == NIB_EXT1) begin
					state_nxt.remaining_bytes = EXT1_BASE + {9'd0, b};
					do_finish = 1'b1;
				end else begin
					state_nxt.extension_high = b;
					state_nxt.phase = PH_L2;
				end
			end
			PH_L2: begin
				state_nxt.remaining_bytes = EXT2_BASE + {1'b0, state_q.extension_high, b};
				do_finish = 1'b1;
			end
			PH_VAL: begin
				has_result           = 1'b1;
				result.kind          = KIND_VALUE;
				result.option_number = run;
				result.value_length  = state_q.pending_delta;
				result.value_byte    = b;
				result.last          = (state_q.remaining_bytes <= 17'd1);
				if (result.last) begin
					state_nxt.remaining_bytes = '0;
					state_nxt.phase = PH_HDR;
				end else begin
					state_nxt.remaining_bytes = state_q.remaining_bytes - 17'd1;
				end
			end
			default: begin
				state_nxt.delta_code  = b[7:4];
				state_nxt.length_code = b[3:0];
				if (b[7:4] == NIB_INVALID || b[3:0] == NIB_INVALID) begin
					do_fail = 1'b1;
				end else if (b[7:4] < NIB_EXT1) begin
					state_nxt.pending_delta = {13'd0, b[7:4]};
					do_after = 1'b1;
				end else begin
					state_nxt.phase = PH_D1;
				end
			end
		endcase

		// Delta is known: either fetch length extensions or close the header.
		if (do_after) begin
			if (state_nxt.length_code inside {NIB_EXT1, NIB_EXT2}) begin
				state_nxt.phase = PH_L1;
			end else begin
				state_nxt.remaining_bytes = {13'd0, state_nxt.length_code};
				do_finish = 1'b1;
			end
		end

		sum = {2'b00, run} + {1'b0, state_nxt.pending_delta};
		if (do_finish) begin
			if (sum[LEN_W:NUM_W] != '0) begin
				do_fail = 1'b1;
			end else begin
				state_nxt.running_number = sum[NUM_W-1:0];
				state_nxt.pending_delta  = state_nxt.remaining_bytes;
				has_result           = 1'b1;
				result.kind          = KIND_HEADER;
				result.option_number = sum[NUM_W-1:0];
				result.value_length  = state_nxt.remaining_bytes;
				result.last          = (state_nxt.remaining_bytes == '0);
				state_nxt.phase      = result.last ? PH_HDR : PH_VAL;
			end
		end

		if (do_fail) begin
			state_nxt.running_number = run;
			state_nxt.phase          = PH_HALT;
			has_result               = 1'b1;
			result                   = '0;
			result.kind              = KIND_ERROR;
			result.option_number     = run;
			result.last              = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_HDR, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end
endmodule

[rtl/core/cohp_out_stage.sv]
// ---------------------------------------------------------------------------
// cohp_out_stage
// Result register that holds one result until the sink takes it.
// ---------------------------------------------------------------------------
module cohp_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   has_result,
	input  cohp_pkg::cohp_result_t result,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cohp_pkg::cohp_result_t result_q
);
	import cohp_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= has_result;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result;
		end
	end
endmodule

[rtl/core/coap_option_header_parser_top.sv]
// ---------------------------------------------------------------------------
// coap_option_header_parser_top
// Byte-serial decoder for the delta/length option headers of a CoAP message.
// ---------------------------------------------------------------------------
// The block takes one byte of a message's options area per transfer and
// accepts a new byte in every cycle while results are taken; the input
// register holds the byte, the result register its result, around the decode
// logic. Raise start_of_options with the first byte of every message: it
// clears the running option number and treats that byte as a header. A
// completed header gives a kind 0 result with the option number and value
// length, each value byte gives a kind 1 result, and last marks the final
// result of an option. Extension bytes give no result. A nibble of fifteen
// (the payload marker included) or an option number beyond 65535 gives a
// kind 2 result, after which bytes are dropped until the next start flag.
module coap_option_header_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	cohp_byte_if.sink            byte_ch,
	cohp_result_if.source        result_ch
);
	import cohp_pkg::*;

	cohp_item_t   in_item;
	cohp_item_t   item_s1;
	logic         valid_s1;
	logic         advance;
	logic         out_free;
	logic         has_result;
	cohp_result_t result;
	cohp_result_t result_q;

	assign in_item.byte_in          = byte_ch.byte_in;
	assign in_item.start_of_options = byte_ch.start_of_options;

	// The held byte is decoded whenever the result register can take what it
	// produces; a byte that gives no result still waits for that slot.
	assign advance = valid_s1 && out_free;

	cohp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_ch.valid),
		.in_ready (byte_ch.ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cohp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_s1    (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	cohp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.has_result (has_result),
		.result     (result),
		.free       (out_free),
		.out_valid  (result_ch.valid),
		.out_ready  (result_ch.ready),
		.result_q   (result_q)
	);

	assign result_ch.kind          = result_q.kind;
	assign result_ch.option_number = result_q.option_number;
	assign result_ch.value_length  = result_q.value_length;
	assign result_ch.value_byte    = result_q.value_byte;
	assign result_ch.last          = result_q.last;
endmodule
